[rtl/lpms_pkg.sv]
// Shared types and constants for the lock-pin motor sequencer.
package lpms_pkg;

  // Default widths and register reset values.
  localparam int unsigned PotBitsDef    = 12;
  localparam int unsigned TimerBitsDef  = 12;
  localparam int unsigned BandBits      = 10;
  localparam int unsigned CfgIdxBits    = 3;
  localparam int unsigned ClosedThrRst  = 800;
  localparam int unsigned OpenThrRst    = 3750;
  localparam int unsigned BandRst       = 100;
  localparam int unsigned TimeoutRst    = 3000;

  // Drive flag bit positions.
  localparam int unsigned DfExt = 0;
  localparam int unsigned DfRet = 1;
  localparam int unsigned DfUnk = 2;
  localparam int unsigned DfOff = 3;
  localparam int unsigned DfStp = 4;

  // Position flag bit positions.
  localparam int unsigned PfOpen   = 0;
  localparam int unsigned PfClosed = 1;
  localparam int unsigned PfElOk   = 2;

  typedef enum logic [2:0] {
    ACT_EXIT    = 3'd0,
    ACT_STOP    = 3'd1,
    ACT_WAIT    = 3'd2,
    ACT_EXTEND  = 3'd3,
    ACT_RETRACT = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    GOAL_OFF       = 2'd0,
    GOAL_OPEN      = 2'd1,
    GOAL_CLOSED    = 2'd2,
    GOAL_UNHANDLED = 2'd3
  } goal_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CLOSED_THR = 3'd0,
    CFG_OPEN_THR   = 3'd1,
    CFG_BAND       = 3'd2,
    CFG_TIMEOUT    = 3'd3
  } cfg_idx_e;

  // One result transaction.
  typedef struct packed {
    action_e     action;
    logic        pin_open;
    logic        pin_closed;
    logic        elevation_ok;
    logic [4:0]  drive_flags;
    logic        timed_out;
    logic        bus_held;
    logic [1:0]  goal_now;
  } result_t;

endpackage

[rtl/lpms_cfg.sv]
// Configuration register file for the lock-pin motor sequencer.
module lpms_cfg #(
  parameter int unsigned POT_BITS   = lpms_pkg::PotBitsDef,
  parameter int unsigned TIMER_BITS = lpms_pkg::TimerBitsDef,
  parameter int unsigned CFG_BITS   = (POT_BITS > TIMER_BITS) ? POT_BITS : TIMER_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [lpms_pkg::CfgIdxBits-1:0]  wr_idx_i,
  input  logic [CFG_BITS-1:0]              wr_data_i,
  output logic [POT_BITS-1:0]              closed_thr_o,
  output logic [POT_BITS-1:0]              open_thr_o,
  output logic [lpms_pkg::BandBits-1:0]    band_o,
  output logic [TIMER_BITS-1:0]            timeout_o
);

  logic [POT_BITS-1:0]           closed_thr_q;
  logic [POT_BITS-1:0]           open_thr_q;
  logic [lpms_pkg::BandBits-1:0] band_q;
  logic [TIMER_BITS-1:0]         timeout_q;
  logic [31:0]                   wide_data;

  // Zero-extend the write data so every register can take its low bits.
  assign wide_data = 32'(wr_data_i);

  // Registers are written by index; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_thr_q <= POT_BITS'(lpms_pkg::ClosedThrRst);
      open_thr_q   <= POT_BITS'(lpms_pkg::OpenThrRst);
      band_q       <= lpms_pkg::BandBits'(lpms_pkg::BandRst);
      timeout_q    <= TIMER_BITS'(lpms_pkg::TimeoutRst);
    end else if (wr_en_i) begin
      case (wr_idx_i)
        lpms_pkg::CFG_CLOSED_THR: closed_thr_q <= wide_data[POT_BITS-1:0];
        lpms_pkg::CFG_OPEN_THR:   open_thr_q   <= wide_data[POT_BITS-1:0];
        lpms_pkg::CFG_BAND:       band_q       <= wide_data[lpms_pkg::BandBits-1:0];
        lpms_pkg::CFG_TIMEOUT:    timeout_q    <= wide_data[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign closed_thr_o = closed_thr_q;
  assign open_thr_o   = open_thr_q;
  assign band_o       = band_q;
  assign timeout_o    = timeout_q;

endmodule

[rtl/lpms_core.sv]
// Sequencer state and per-transaction decision logic.
module lpms_core #(
  parameter int unsigned POT_BITS   = lpms_pkg::PotBitsDef,
  parameter int unsigned TIMER_BITS = lpms_pkg::TimerBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_en_i,
  input  logic                          cmd_i,
  input  logic [POT_BITS-1:0]           pot_i,
  input  logic                          el_in_range_i,
  input  logic [1:0]                    goal_code_i,
  input  logic                          force_reset_i,
  input  logic                          ignore_elevation_i,
  input  logic [POT_BITS-1:0]           closed_thr_i,
  input  logic [POT_BITS-1:0]           open_thr_i,
  input  logic [lpms_pkg::BandBits-1:0] band_i,
  input  logic [TIMER_BITS-1:0]         timeout_i,
  output lpms_pkg::result_t             result_o
);

  localparam int unsigned MaxW  = (POT_BITS > lpms_pkg::BandBits) ? POT_BITS
                                                                  : lpms_pkg::BandBits;
  localparam int unsigned SumW  = MaxW + 1;

  logic [4:0]            drive_q, drive_d, drive_fix;
  logic [2:0]            pos_q, pos_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d, cnt_dec;
  lpms_pkg::goal_e       goal_q, goal_d;
  logic                  force_q, force_d;
  logic                  ign_q, ign_d;

  lpms_pkg::action_e     act_pick, act_fin;
  lpms_pkg::goal_e       goal_tick;
  logic                  tmo;
  logic [SumW-1:0]       pot_w, closed_sum, open_sum;
  logic                  in_band;

  // Widened band sums so the tests never wrap.
  assign pot_w      = SumW'(pot_i);
  assign closed_sum = SumW'(closed_thr_i) + SumW'(band_i);
  assign open_sum   = pot_w + SumW'(band_i);
  assign in_band    = (pot_w < closed_sum) || (open_sum > SumW'(open_thr_i));

  // On contradictory drive flags or a pending forced reset, clear all but the unknown flag.
  always_comb begin
    drive_fix = drive_q;
    if (((drive_q[lpms_pkg::DfExt] || drive_q[lpms_pkg::DfRet] ||
          drive_q[lpms_pkg::DfUnk]) && drive_q[lpms_pkg::DfOff]) || force_q) begin
      drive_fix = 5'b0;
      drive_fix[lpms_pkg::DfUnk] = drive_q[lpms_pkg::DfUnk];
    end
  end

  // Classify the pin with hysteresis; inside the band the old status holds.
  always_comb begin
    pos_d = 3'b0;
    if (pot_i < closed_thr_i) begin
      pos_d[lpms_pkg::PfClosed] = 1'b1;
    end else if (pot_i > open_thr_i) begin
      pos_d[lpms_pkg::PfOpen] = 1'b1;
    end else if (in_band) begin
      pos_d[1:0] = pos_q[1:0];
    end
    pos_d[lpms_pkg::PfElOk] = el_in_range_i;
  end

  // Pick the action for the stored goal.
  always_comb begin
    act_pick  = lpms_pkg::ACT_EXIT;
    goal_tick = goal_q;
    case (goal_q)
      lpms_pkg::GOAL_OPEN: begin
        if (pos_d[lpms_pkg::PfOpen] && drive_fix[lpms_pkg::DfOff]) begin
          act_pick = lpms_pkg::ACT_EXIT;
        end else if (pos_d[lpms_pkg::PfOpen]) begin
          act_pick = lpms_pkg::ACT_STOP;
        end else if (drive_fix[lpms_pkg::DfRet]) begin
          act_pick = lpms_pkg::ACT_WAIT;
        end else if (drive_fix[lpms_pkg::DfOff]) begin
          act_pick = lpms_pkg::ACT_RETRACT;
        end else begin
          act_pick = lpms_pkg::ACT_STOP;
        end
      end
      lpms_pkg::GOAL_CLOSED: begin
        if (pos_d[lpms_pkg::PfClosed] && drive_fix[lpms_pkg::DfOff]) begin
          act_pick = lpms_pkg::ACT_EXIT;
        end else if (pos_d[lpms_pkg::PfClosed]) begin
          act_pick = lpms_pkg::ACT_STOP;
        end else if (pos_d[lpms_pkg::PfElOk] || ign_q) begin
          if (pos_d[lpms_pkg::PfOpen] && drive_fix[lpms_pkg::DfStp]) begin
            act_pick = lpms_pkg::ACT_WAIT;
          end else if (drive_fix[lpms_pkg::DfExt]) begin
            act_pick = lpms_pkg::ACT_WAIT;
          end else if (drive_fix[lpms_pkg::DfStp]) begin
            act_pick = lpms_pkg::ACT_STOP;
          end else if (drive_fix[lpms_pkg::DfOff]) begin
            act_pick = lpms_pkg::ACT_EXTEND;
          end else begin
            act_pick = lpms_pkg::ACT_STOP;
          end
        end else if (drive_fix[lpms_pkg::DfOff]) begin
          act_pick = lpms_pkg::ACT_WAIT;
        end else begin
          act_pick = lpms_pkg::ACT_STOP;
        end
      end
      lpms_pkg::GOAL_OFF: begin
        act_pick = drive_fix[lpms_pkg::DfOff] ? lpms_pkg::ACT_EXIT : lpms_pkg::ACT_STOP;
      end
      default: begin
        // An unhandled goal falls back to off.
        act_pick  = lpms_pkg::ACT_EXIT;
        goal_tick = lpms_pkg::GOAL_OFF;
      end
    endcase
  end

  // Timeout override and the drive and counter updates that follow.
  assign tmo     = (cnt_q == TIMER_BITS'(1));
  assign act_fin = tmo ? lpms_pkg::ACT_STOP : act_pick;
  assign cnt_dec = (cnt_q != '0) ? cnt_q - TIMER_BITS'(1) : cnt_q;

  always_comb begin
    drive_d  = drive_q;
    cnt_d    = cnt_q;
    goal_d   = goal_q;
    force_d  = force_q;
    ign_d    = ign_q;
    result_o = '0;
    if (cmd_i) begin
      goal_d  = lpms_pkg::goal_e'(goal_code_i);
      force_d = force_reset_i;
      ign_d   = ignore_elevation_i;
      result_o.action       = lpms_pkg::ACT_EXIT;
      result_o.pin_open     = pos_q[lpms_pkg::PfOpen];
      result_o.pin_closed   = pos_q[lpms_pkg::PfClosed];
      result_o.elevation_ok = pos_q[lpms_pkg::PfElOk];
      result_o.drive_flags  = drive_q;
      result_o.goal_now     = (goal_code_i == lpms_pkg::GOAL_UNHANDLED) ?
                              lpms_pkg::GOAL_OFF : goal_code_i;
    end else begin
      force_d = 1'b0;
      goal_d  = goal_tick;
      case (act_fin)
        lpms_pkg::ACT_STOP: begin
          cnt_d   = '0;
          drive_d = 5'b0;
          drive_d[lpms_pkg::DfOff] = 1'b1;
        end
        lpms_pkg::ACT_EXTEND: begin
          cnt_d   = timeout_i;
          drive_d = 5'b0;
          drive_d[lpms_pkg::DfExt] = 1'b1;
        end
        lpms_pkg::ACT_RETRACT: begin
          cnt_d   = timeout_i;
          drive_d = 5'b0;
          drive_d[lpms_pkg::DfRet] = 1'b1;
        end
        default: begin
          cnt_d   = cnt_dec;
          drive_d = drive_fix;
        end
      endcase
      result_o.action       = act_fin;
      result_o.pin_open     = pos_d[lpms_pkg::PfOpen];
      result_o.pin_closed   = pos_d[lpms_pkg::PfClosed];
      result_o.elevation_ok = pos_d[lpms_pkg::PfElOk];
      result_o.drive_flags  = drive_d;
      result_o.timed_out    = tmo;
      result_o.bus_held     = (act_fin != lpms_pkg::ACT_EXIT);
      result_o.goal_now     = goal_tick;
    end
  end

  // Sequencer state advances once per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= 5'b1 << lpms_pkg::DfUnk;
      pos_q   <= 3'b0;
      cnt_q   <= '0;
      goal_q  <= lpms_pkg::GOAL_OFF;
      force_q <= 1'b0;
      ign_q   <= 1'b0;
    end else if (step_en_i) begin
      drive_q <= drive_d;
      pos_q   <= cmd_i ? pos_q : pos_d;
      cnt_q   <= cnt_d;
      goal_q  <= goal_d;
      force_q <= force_d;
      ign_q   <= ign_d;
    end
  end

endmodule

[rtl/lock_pin_motor_sequencer.sv]
// Top level of the lock-pin motor sequencer: input and result registers.
//
//  Channel | Direction | Handshake             | Payload
//  in      | input     | in_valid_i/in_ready_o | cmd, pot, el_in_range, goal_code, ...
//  out     | output    | out_valid_o/out_ready_i | action, pin flags, drive_flags, ...
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_idx_i, cfg_data_i
//
// A transaction enters the input register when it is accepted, then passes
// through the decision logic into the result register, from which its
// result is taken. One transaction per cycle is sustained while out_ready_i
// stays high.
// Reset puts the drive flags at unknown only, with the goal off.
// A stalled result holds both stages; the input side takes a new
// transaction whenever the input register is empty or drains this cycle.
module lock_pin_motor_sequencer #(
  parameter int unsigned POT_BITS   = lpms_pkg::PotBitsDef,
  parameter int unsigned TIMER_BITS = lpms_pkg::TimerBitsDef,
  parameter int unsigned CFG_BITS   = (POT_BITS > TIMER_BITS) ? POT_BITS : TIMER_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            cmd_i,
  input  logic [POT_BITS-1:0]             pot_i,
  input  logic                            el_in_range_i,
  input  logic [1:0]                      goal_code_i,
  input  logic                            force_reset_i,
  input  logic                            ignore_elevation_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      action_o,
  output logic                            pin_open_o,
  output logic                            pin_closed_o,
  output logic                            elevation_ok_o,
  output logic [4:0]                      drive_flags_o,
  output logic                            timed_out_o,
  output logic                            bus_held_o,
  output logic [1:0]                      goal_now_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lpms_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]             cfg_data_i
);

  logic                          s1_valid_q;
  logic                          s1_cmd_q;
  logic [POT_BITS-1:0]           s1_pot_q;
  logic                          s1_el_q;
  logic [1:0]                    s1_goal_q;
  logic                          s1_force_q;
  logic                          s1_ign_q;
  logic                          advance;
  logic                          in_fire;
  logic                          res_valid_q;
  lpms_pkg::result_t             res_q;
  lpms_pkg::result_t             res_d;
  logic [POT_BITS-1:0]           closed_thr;
  logic [POT_BITS-1:0]           open_thr;
  logic [lpms_pkg::BandBits-1:0] band;
  logic [TIMER_BITS-1:0]         timeout;

  assign cfg_ready_o = 1'b1;

  lpms_cfg #(
    .POT_BITS  (POT_BITS),
    .TIMER_BITS(TIMER_BITS),
    .CFG_BITS  (CFG_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (cfg_valid_i),
    .wr_idx_i    (cfg_idx_i),
    .wr_data_i   (cfg_data_i),
    .closed_thr_o(closed_thr),
    .open_thr_o  (open_thr),
    .band_o      (band),
    .timeout_o   (timeout)
  );

  // Stage handshake: the input register drains when the result slot frees.
  assign advance    = s1_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q   <= cmd_i;
      s1_pot_q   <= pot_i;
      s1_el_q    <= el_in_range_i;
      s1_goal_q  <= goal_code_i;
      s1_force_q <= force_reset_i;
      s1_ign_q   <= ignore_elevation_i;
    end
  end

  lpms_core #(
    .POT_BITS  (POT_BITS),
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_en_i         (advance),
    .cmd_i             (s1_cmd_q),
    .pot_i             (s1_pot_q),
    .el_in_range_i     (s1_el_q),
    .goal_code_i       (s1_goal_q),
    .force_reset_i     (s1_force_q),
    .ignore_elevation_i(s1_ign_q),
    .closed_thr_i      (closed_thr),
    .open_thr_i        (open_thr),
    .band_i            (band),
    .timeout_i         (timeout),
    .result_o          (res_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign action_o       = res_q.action;
  assign pin_open_o     = res_q.pin_open;
  assign pin_closed_o   = res_q.pin_closed;
  assign elevation_ok_o = res_q.elevation_ok;
  assign drive_flags_o  = res_q.drive_flags;
  assign timed_out_o    = res_q.timed_out;
  assign bus_held_o     = res_q.bus_held;
  assign goal_now_o     = res_q.goal_now;

`ifndef SYNTHESIS
  // A timeout always shows up as a stop.
  a_timeout_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && timed_out_o) |-> (action_o == lpms_pkg::ACT_STOP))
    else $error("timeout without stop action");

  // The shown goal is never the unhandled code.
  a_goal_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (goal_now_o != lpms_pkg::GOAL_UNHANDLED))
    else $error("unhandled goal shown");

  // A stalled result must keep the input stage from draining.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && s1_valid_q) |=> (s1_valid_q && out_valid_o))
    else $error("pipeline advanced during a stall");
`endif

endmodule

[tb/sv/lock_pin_motor_sequencer_tb.sv]
// Self-checking testbench for the lock-pin motor sequencer with a tracking scoreboard.
`timescale 1ns / 1ps

module lock_pin_motor_sequencer_tb;
  import lpms_pkg::*;

  localparam int unsigned PotW  = PotBitsDef;
  localparam int unsigned TmrW  = TimerBitsDef;
  localparam int unsigned CfgW  = (PotBitsDef > TimerBitsDef) ? PotBitsDef : TimerBitsDef;

  // Input command codes.
  localparam logic CmdTick = 1'b0;
  localparam logic CmdGoal = 1'b1;

  // Drive and position flag masks.
  localparam logic [4:0] FlagExt = 5'(1 << DfExt);
  localparam logic [4:0] FlagRet = 5'(1 << DfRet);
  localparam logic [4:0] FlagUnk = 5'(1 << DfUnk);
  localparam logic [4:0] FlagOff = 5'(1 << DfOff);
  localparam logic [4:0] MovingOrUnk = FlagExt | FlagRet | FlagUnk;
  localparam logic [2:0] PinMask = 3'((1 << PfOpen) | (1 << PfClosed));

  localparam int unsigned NumPhases   = 10;
  localparam int unsigned PhaseItems  = 195;
  localparam int unsigned DrainLimit  = 10000;

  // Tracks the sequencer state and holds the decisions still to come out.
  class sequencer_tracker;
    logic [PotW-1:0] closed_thr;
    logic [PotW-1:0] open_thr;
    logic [BandBits-1:0] band;
    logic [TmrW-1:0] tmo_load;

    logic [4:0] drive;
    logic [2:0] pos;
    logic [TmrW-1:0] tmo_cnt;
    goal_e goal;
    logic force_pend;
    logic ign_el;

    result_t decision_q[$];
    action_e last_action;
    int unsigned errors;

    function new();
      closed_thr = PotW'(ClosedThrRst);
      open_thr   = PotW'(OpenThrRst);
      band       = BandBits'(BandRst);
      tmo_load   = TmrW'(TimeoutRst);
      drive      = FlagUnk;
      pos        = '0;
      tmo_cnt    = '0;
      goal       = GOAL_OFF;
      force_pend = 1'b0;
      ign_el     = 1'b0;
      last_action = ACT_EXIT;
      errors     = 0;
    endfunction

    // A register write; unknown indexes change nothing.
    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_CLOSED_THR: closed_thr = data[PotW-1:0];
        CFG_OPEN_THR:   open_thr = data[PotW-1:0];
        CFG_BAND:       band = data[BandBits-1:0];
        CFG_TIMEOUT:    tmo_load = data[TmrW-1:0];
        default: ;
      endcase
    endfunction

    // Open/closed classification; inside the band the old status is kept.
    function logic [2:0] classify_pin(logic [PotW-1:0] pot, logic el);
      logic [2:0] pf;
      int unsigned p, c, o, b;
      p = pot;
      c = closed_thr;
      o = open_thr;
      b = band;
      pf = '0;
      if (p < c) pf[PfClosed] = 1'b1;
      else if (p > o) pf[PfOpen] = 1'b1;
      else if ((p < c + b) || (p + b > o)) pf = pos & PinMask;
      pf[PfElOk] = el;
      return pf;
    endfunction

    // Action from the goal, the stored drive flags and the position.
    function action_e pick_action();
      logic is_open, is_closed, el_ok;
      logic d_ext, d_ret, d_off, d_stp;
      is_open   = pos[PfOpen];
      is_closed = pos[PfClosed];
      el_ok     = pos[PfElOk];
      d_ext = drive[DfExt];
      d_ret = drive[DfRet];
      d_off = drive[DfOff];
      d_stp = drive[DfStp];
      case (goal)
        GOAL_OPEN: begin
          if (is_open && d_off) return ACT_EXIT;
          if (is_open) return ACT_STOP;
          if (d_ret) return ACT_WAIT;
          if (d_off) return ACT_RETRACT;
          return ACT_STOP;
        end
        GOAL_CLOSED: begin
          if (is_closed && d_off) return ACT_EXIT;
          if (is_closed) return ACT_STOP;
          if (el_ok || ign_el) begin
            if (is_open && d_stp) return ACT_WAIT;
            if (d_ext) return ACT_WAIT;
            if (d_stp) return ACT_STOP;
            if (d_off) return ACT_EXTEND;
            return ACT_STOP;
          end
          return d_off ? ACT_WAIT : ACT_STOP;
        end
        GOAL_OFF: return d_off ? ACT_EXIT : ACT_STOP;
        default: begin
          goal = GOAL_OFF;
          return ACT_EXIT;
        end
      endcase
    endfunction

    // Applies one accepted input transaction and queues its decision.
    function void take_item(logic cmd, logic [PotW-1:0] pot, logic el, goal_e g,
                            logic frc, logic ign);
      result_t r;
      action_e act;
      logic tmo;
      act = ACT_EXIT;
      tmo = 1'b0;
      if (cmd == CmdGoal) begin
        goal = g;
        force_pend = frc;
        ign_el = ign;
      end else begin
        // Contradictory flags or a forced reset leave only the unknown flag.
        if ((((drive & MovingOrUnk) != '0) && drive[DfOff]) || force_pend) begin
          drive = drive & FlagUnk;
          force_pend = 1'b0;
        end
        pos = classify_pin(pot, el);
        act = pick_action();
        if (tmo_cnt == TmrW'(1)) begin
          act = ACT_STOP;
          tmo = 1'b1;
        end
        if (tmo_cnt != '0) tmo_cnt = tmo_cnt - 1'b1;
        case (act)
          ACT_STOP: begin
            tmo_cnt = '0;
            drive = FlagOff;
          end
          ACT_EXTEND: begin
            tmo_cnt = tmo_load;
            drive = FlagExt;
          end
          ACT_RETRACT: begin
            tmo_cnt = tmo_load;
            drive = FlagRet;
          end
          default: ;
        endcase
        last_action = act;
      end
      r.action       = act;
      r.pin_open     = pos[PfOpen];
      r.pin_closed   = pos[PfClosed];
      r.elevation_ok = pos[PfElOk];
      r.drive_flags  = drive;
      r.timed_out    = tmo;
      r.bus_held     = (act != ACT_EXIT);
      r.goal_now     = (goal == GOAL_UNHANDLED) ? GOAL_OFF : goal;
      decision_q.push_back(r);
    endfunction

    function int unsigned pending();
      return decision_q.size();
    endfunction

    function void compare_field(string name, logic [4:0] exp_v, logic [4:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    // Compares one result transaction with the oldest queued decision.
    function void check_result(result_t got);
      result_t exp_r;
      if (decision_q.size() == 0) begin
        $error("result transaction with no decision waiting");
        errors++;
        return;
      end
      exp_r = decision_q.pop_front();
      compare_field("action", 5'(exp_r.action), 5'(got.action));
      compare_field("pin_open", 5'(exp_r.pin_open), 5'(got.pin_open));
      compare_field("pin_closed", 5'(exp_r.pin_closed), 5'(got.pin_closed));
      compare_field("elevation_ok", 5'(exp_r.elevation_ok), 5'(got.elevation_ok));
      compare_field("drive_flags", exp_r.drive_flags, got.drive_flags);
      compare_field("timed_out", 5'(exp_r.timed_out), 5'(got.timed_out));
      compare_field("bus_held", 5'(exp_r.bus_held), 5'(got.bus_held));
      compare_field("goal_now", 5'(exp_r.goal_now), 5'(got.goal_now));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic cmd_i;
  logic [PotW-1:0] pot_i;
  logic el_in_range_i;
  logic [1:0] goal_code_i;
  logic force_reset_i;
  logic ignore_elevation_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [2:0] action_o;
  logic pin_open_o;
  logic pin_closed_o;
  logic elevation_ok_o;
  logic [4:0] drive_flags_o;
  logic timed_out_o;
  logic bus_held_o;
  logic [1:0] goal_now_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  sequencer_tracker trk;
  bit calm;
  int stall_left;
  int pin_pos;
  int motion;

  lock_pin_motor_sequencer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .pot_i              (pot_i),
    .el_in_range_i      (el_in_range_i),
    .goal_code_i        (goal_code_i),
    .force_reset_i      (force_reset_i),
    .ignore_elevation_i (ignore_elevation_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .action_o           (action_o),
    .pin_open_o         (pin_open_o),
    .pin_closed_o       (pin_closed_o),
    .elevation_ok_o     (elevation_ok_o),
    .drive_flags_o      (drive_flags_o),
    .timed_out_o        (timed_out_o),
    .bus_held_o         (bus_held_o),
    .goal_now_o         (goal_now_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls, mostly short, off in calm phases.
  always @(posedge clk_i) begin
    int r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(14, 49);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Every accepted result transaction is checked against the tracker.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      got.action       = action_e'(action_o);
      got.pin_open     = pin_open_o;
      got.pin_closed   = pin_closed_o;
      got.elevation_ok = elevation_ok_o;
      got.drive_flags  = drive_flags_o;
      got.timed_out    = timed_out_o;
      got.bus_held     = bus_held_o;
      got.goal_now     = goal_now_o;
      trk.check_result(got);
    end
  end

  // Presents one input transaction and waits for it to be taken; valid stays high.
  task automatic send(input logic cmd, input logic [PotW-1:0] pot, input logic el,
                      input goal_e g, input logic frc, input logic ign);
    in_valid_i         <= 1'b1;
    cmd_i              <= cmd;
    pot_i              <= pot;
    el_in_range_i      <= el;
    goal_code_i        <= g;
    force_reset_i      <= frc;
    ignore_elevation_i <= ign;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    trk.take_item(cmd, pot, el, g, frc, ign);
    // The simulated pin follows the motor the sequencer is commanding.
    if (cmd == CmdTick) begin
      case (trk.last_action)
        ACT_EXTEND:  motion = -1;
        ACT_RETRACT: motion = 1;
        ACT_STOP:    motion = 0;
        default: ;
      endcase
    end
  endtask

  // Sender gap of random length.
  task automatic idle_gap();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (calm || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender until every queued decision has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (trk.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One register write transaction; valid stays high for the next.
  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    trk.write_reg(idx, data);
  endtask

  // Writes all registers plus one unused index; the block must be idle.
  task automatic configure(input logic [CfgW-1:0] closed_v, input logic [CfgW-1:0] open_v,
                           input logic [CfgW-1:0] band_v, input logic [CfgW-1:0] tmo_v);
    cfg_write(CfgIdxBits'(CFG_TIMEOUT) + CfgIdxBits'($urandom_range(1, 4)), CfgW'($urandom));
    cfg_write(CFG_CLOSED_THR, closed_v);
    cfg_write(CFG_OPEN_THR, open_v);
    cfg_write(CFG_BAND, band_v);
    cfg_write(CFG_TIMEOUT, tmo_v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hand-picked transactions that walk through the main decisions.
  task automatic directed_items();
    // Reset state: unknown drive, goal off.
    send(CmdTick, 12'd2000, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    send(CmdGoal, '1, 1'b1, GOAL_OPEN, 1'b0, 1'b0);
    send(CmdTick, '0, 1'b1, GOAL_UNHANDLED, 1'b1, 1'b1);
    idle_gap();
    send(CmdTick, 12'd2000, 1'b1, GOAL_OFF, 1'b0, 1'b0);
    send(CmdTick, '1, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    send(CmdTick, '1, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    // Inside the band near the open threshold the open status is kept.
    send(CmdTick, 12'd3700, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    idle_gap();
    send(CmdGoal, 12'd5, 1'b0, GOAL_CLOSED, 1'b0, 1'b0);
    send(CmdTick, 12'd3751, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    send(CmdTick, 12'd4000, 1'b1, GOAL_OFF, 1'b0, 1'b0);
    send(CmdTick, 12'd2000, 1'b1, GOAL_OFF, 1'b0, 1'b0);
    send(CmdTick, 12'd799, 1'b1, GOAL_OFF, 1'b0, 1'b0);
    send(CmdTick, 12'd850, 1'b1, GOAL_OFF, 1'b0, 1'b0);
    idle_gap();
    // Unhandled goal with a forced reset.
    send(CmdGoal, 12'd0, 1'b1, GOAL_UNHANDLED, 1'b1, 1'b1);
    send(CmdTick, 12'd2000, 1'b0, GOAL_CLOSED, 1'b0, 1'b1);
    send(CmdTick, 12'd2000, 1'b0, GOAL_OPEN, 1'b1, 1'b0);
    send(CmdTick, 12'd2000, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    // Closing regardless of elevation, then a forced reset while extending.
    send(CmdGoal, 12'd0, 1'b0, GOAL_CLOSED, 1'b0, 1'b1);
    send(CmdTick, 12'd3000, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    send(CmdGoal, 12'd0, 1'b0, GOAL_OFF, 1'b1, 1'b0);
    send(CmdTick, 12'd3000, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    // Short timeout forces a stop two ticks after an extend.
    drain();
    configure(CfgW'(ClosedThrRst), CfgW'(OpenThrRst), CfgW'(BandRst), CfgW'(2));
    send(CmdGoal, 12'd0, 1'b0, GOAL_CLOSED, 1'b0, 1'b1);
    send(CmdTick, 12'd3000, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    send(CmdTick, 12'd2500, 1'b0, GOAL_OFF, 1'b0, 1'b0);
    send(CmdTick, 12'd2000, 1'b0, GOAL_OFF, 1'b0, 1'b0);
  endtask

  // Random goals and ticks; tick samples mostly track the simulated pin.
  task automatic random_items(input int unsigned count);
    int r;
    int s;
    int p;
    goal_e g;
    logic [PotW-1:0] pot;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        s = $urandom_range(0, 19);
        if (s < 7) g = GOAL_OPEN;
        else if (s < 14) g = GOAL_CLOSED;
        else if (s < 18) g = GOAL_OFF;
        else g = GOAL_UNHANDLED;
        send(CmdGoal, PotW'($urandom), 1'($urandom), g, ($urandom_range(0, 4) == 0),
             1'($urandom));
      end else begin
        pin_pos = pin_pos + motion * $urandom_range(20, 400);
        if (pin_pos < 0) pin_pos = 0;
        if (pin_pos > 4095) pin_pos = 4095;
        s = $urandom_range(0, 99);
        if (s < 8) begin
          pot = PotW'($urandom);
        end else if (s < 12) begin
          pot = s[0] ? '1 : '0;
        end else begin
          p = pin_pos + $urandom_range(0, 16) - 8;
          if (p < 0) p = 0;
          if (p > 4095) p = 4095;
          pot = PotW'(p);
        end
        send(CmdTick, pot, ($urandom_range(0, 3) != 0), goal_e'($urandom_range(0, 3)),
             1'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 199) == 0) drain();
      idle_gap();
    end
  endtask

  // Main sequence: reset, directed part, then random phases over several settings.
  initial begin
    int unsigned waited;
    trk = new();
    calm = 1'b0;
    stall_left = 0;
    pin_pos = 2000;
    motion = 0;
    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    cmd_i              <= CmdTick;
    pot_i              <= '0;
    el_in_range_i      <= 1'b0;
    goal_code_i        <= GOAL_OFF;
    force_reset_i      <= 1'b0;
    ignore_elevation_i <= 1'b0;
    out_ready_i        <= 1'b0;
    cfg_valid_i        <= 1'b0;
    cfg_idx_i          <= CFG_CLOSED_THR;
    cfg_data_i         <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: configure(CfgW'(ClosedThrRst), CfgW'(OpenThrRst), CfgW'(BandRst),
                     CfgW'(TimeoutRst));
        1: configure('0, '1, '0, CfgW'(1));
        2: configure('1, '0, CfgW'(10'h3FF), '1);
        // A zero load means the drive never times out.
        3: configure(CfgW'($urandom_range(0, 1500)), CfgW'($urandom_range(2500, 4095)),
                     CfgW'($urandom), '0);
        default: configure(CfgW'($urandom_range(0, 2000)), CfgW'($urandom_range(1800, 4095)),
                           CfgW'($urandom),
                           ($urandom_range(0, 9) == 0) ? CfgW'($urandom_range(1, 4095))
                                                       : CfgW'($urandom_range(1, 40)));
      endcase
      calm = (ph % 4 == 2);
      random_items(PhaseItems);
    end

    // Let the last decisions come out.
    calm = 1'b0;
    in_valid_i <= 1'b0;
    waited = 0;
    while (trk.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (trk.pending() != 0) begin
      $error("%0d decisions never came out", trk.pending());
      trk.errors++;
    end
    if (trk.errors == 0) begin
      $display("** lock_pin_motor_sequencer: PASSED **");
    end else begin
      $display("** lock_pin_motor_sequencer: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #15_000_000;
    $display("** lock_pin_motor_sequencer: FAILED **");
    $finish;
  end

endmodule
